@@ rtl/grm_pkg.sv @@
// shared types, constants and register map of the grayscale row mirror
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

    // line store
    localparam int MAX_WIDTH_DEFAULT = 2048;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // config port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int ROW_WIDTH_W = 12;
    localparam int WEIGHT_W = 9;

    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_WEIGHT_RED   = 2'd1;
    localparam logic [1:0] REG_WEIGHT_GREEN = 2'd2;
    localparam logic [1:0] REG_WEIGHT_BLUE  = 2'd3;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST    = 12'd640;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RED_RST   = 9'd54;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_GREEN_RST = 9'd184;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_BLUE_RST  = 9'd18;

    // input kind codes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_IDLE  = 1'b1;

    localparam int COMP_W = 8;
    localparam int PROD_W = WEIGHT_W + COMP_W;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic wr;
    } cmd_ctl_t;

    typedef struct packed {
        logic [PROD_W-1:0] red;
        logic [PROD_W-1:0] green;
        logic [PROD_W-1:0] blue;
    } prod_t;

endpackage

`default_nettype wire

@@ rtl/grayscale_row_mirror_core.sv @@
// Grayscale conversion with horizontal row mirroring, top level.
//
// Input words on the s_ channel carry an RGB pixel (s_tuser low) or an idle
// tick (s_tuser high). A pixel is weighted into a gray value and written into
// the filling bank of a two-bank line store. Once row_width pixels are in,
// the banks swap and every following input word, pixel or idle, releases one
// pixel of that row on the m_ channel, last column first, with m_tlast on the
// final pixel of the row.
// Throughput is one input word per cycle; a word is taken every cycle while
// the command queue between front and back has room. The result that an input
// word releases passes through the command queue, the line store read
// register and the result buffer, in that order.
// When m_tready is held low the result buffer fills, then the back end holds
// any command that releases a result, and s_tready falls once the command
// queue is full.
// Reset clears row position, bank select and pending drain count and restores
// the register defaults (width 640, weights 54/184/18). The line store is not
// cleared; entries are only read after being written.
// Registers sit on the APB port at 0x0, 0x4, 0x8, 0xC.
`timescale 1ns / 1ps
`default_nettype none

module grayscale_row_mirror_core import grm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,     // red [7:0], green [15:8], blue [23:16]
    input  wire logic                  s_tuser,     // kind
    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,     // gray [7:0]
    output logic                       m_tlast,     // row_end
    // config
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int ADDR_W = $clog2(MAX_WIDTH) + 1;
    localparam int CMD_W  = $bits(cmd_ctl_t) + $bits(prod_t) + 2 * ADDR_W;

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [WEIGHT_W-1:0]    weight_red_reg;
    logic [WEIGHT_W-1:0]    weight_green_reg;
    logic [WEIGHT_W-1:0]    weight_blue_reg;
    logic                   cfg_wr;
    logic [1:0]             reg_idx;

    cmd_ctl_t               f_ctl, b_ctl;
    prod_t                  f_prod, b_prod;
    logic [ADDR_W-1:0]      f_rd_addr, f_wr_addr, b_rd_addr, b_wr_addr;
    logic                   f_valid, f_ready, b_valid, b_ready;
    logic [CMD_W-1:0]       q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= ROW_WIDTH_RST;
            weight_red_reg   <= WEIGHT_RED_RST;
            weight_green_reg <= WEIGHT_GREEN_RST;
            weight_blue_reg  <= WEIGHT_BLUE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ROW_WIDTH:    row_width_reg    <= pwdata[ROW_WIDTH_W-1:0];
                REG_WEIGHT_RED:   weight_red_reg   <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_GREEN: weight_green_reg <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_BLUE:  weight_blue_reg  <= pwdata[WEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW_WIDTH:    prdata = CFG_DATA_W'(row_width_reg);
            REG_WEIGHT_RED:   prdata = CFG_DATA_W'(weight_red_reg);
            REG_WEIGHT_GREEN: prdata = CFG_DATA_W'(weight_green_reg);
            REG_WEIGHT_BLUE:  prdata = CFG_DATA_W'(weight_blue_reg);
            default:          prdata = '0;
        endcase
    end

    grm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .row_width    (row_width_reg),
        .weight_red   (weight_red_reg),
        .weight_green (weight_green_reg),
        .weight_blue  (weight_blue_reg),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd_ctl      (f_ctl),
        .cmd_prod     (f_prod),
        .cmd_rd_addr  (f_rd_addr),
        .cmd_wr_addr  (f_wr_addr)
    );

    grm_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_prod, f_rd_addr, f_wr_addr}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out),
        .count      ()
    );

    assign {b_ctl, b_prod, b_rd_addr, b_wr_addr} = q_out;

    grm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (b_valid),
        .cmd_ready   (b_ready),
        .cmd_ctl     (b_ctl),
        .cmd_prod    (b_prod),
        .cmd_rd_addr (b_rd_addr),
        .cmd_wr_addr (b_wr_addr),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/grm_queue.sv @@
// small register fifo used between front and back and on the result side
`timescale 1ns / 1ps
`default_nettype none

module grm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           push_valid,
    output logic                                push_ready,
    input  wire logic [DATA_W-1:0]              push_data,
    output logic                                pop_valid,
    input  wire logic                           pop_ready,
    output logic [DATA_W-1:0]                   pop_data,
    output logic [$clog2(DEPTH+1)-1:0]          count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_do, pop_do;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    assign push_do = push_valid && push_ready;
    assign pop_do  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_do) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_do) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_do && !pop_do) begin
            count_next = count_reg + 1'b1;
        end else if (pop_do && !push_do) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_do) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/grm_front.sv @@
// front end: accepts words, tracks fill and drain position, forms line store commands
`timescale 1ns / 1ps
`default_nettype none

module grm_front import grm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_tuser,     // kind
    input  wire logic [23:0]                   s_tdata,     // red, green, blue
    input  wire logic [ROW_WIDTH_W-1:0]        row_width,
    input  wire logic [WEIGHT_W-1:0]           weight_red,
    input  wire logic [WEIGHT_W-1:0]           weight_green,
    input  wire logic [WEIGHT_W-1:0]           weight_blue,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output cmd_ctl_t                           cmd_ctl,
    output prod_t                              cmd_prod,
    output logic [$clog2(MAX_WIDTH):0]         cmd_rd_addr,
    output logic [$clog2(MAX_WIDTH):0]         cmd_wr_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    logic             fill_bank_reg, fill_bank_next;
    logic [COL_W-1:0] fill_col_reg, fill_col_next;
    logic [CNT_W-1:0] drain_rem_reg, drain_rem_next;
    logic [CNT_W-1:0] eff_width;
    logic [CNT_W-1:0] written;
    logic [CNT_W-1:0] drain_dec;
    logic             accept;
    logic             is_pixel;

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign accept    = s_tvalid && cmd_ready;
    assign is_pixel  = (s_tuser == KIND_PIXEL);

    // zero acts as one, anything above the store size is clamped
    always_comb begin
        if (row_width == '0) begin
            eff_width = CNT_W'(1);
        end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
            eff_width = CNT_W'(MAX_WIDTH);
        end else begin
            eff_width = CNT_W'(row_width);
        end
    end

    assign written   = CNT_W'(fill_col_reg) + 1'b1;
    assign drain_dec = drain_rem_reg - 1'b1;

    always_comb begin
        cmd_ctl.emit    = (drain_rem_reg != '0);
        cmd_ctl.row_end = (drain_rem_reg == CNT_W'(1));
        cmd_ctl.wr      = is_pixel;
        cmd_rd_addr     = {~fill_bank_reg, drain_dec[COL_W-1:0]};
        cmd_wr_addr     = {fill_bank_reg, fill_col_reg};
        cmd_prod.red    = PROD_W'(weight_red)   * PROD_W'(s_tdata[7:0]);
        cmd_prod.green  = PROD_W'(weight_green) * PROD_W'(s_tdata[15:8]);
        cmd_prod.blue   = PROD_W'(weight_blue)  * PROD_W'(s_tdata[23:16]);
    end

    always_comb begin
        fill_bank_next = fill_bank_reg;
        fill_col_next  = fill_col_reg;
        drain_rem_next = (drain_rem_reg != '0) ? drain_dec : drain_rem_reg;
        if (is_pixel) begin
            if (written >= eff_width) begin
                // row complete: swap banks and start draining it
                fill_bank_next = ~fill_bank_reg;
                fill_col_next  = '0;
                drain_rem_next = written;
            end else begin
                fill_col_next = written[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_bank_reg <= 1'b0;
            fill_col_reg  <= '0;
            drain_rem_reg <= '0;
        end else if (accept) begin
            fill_bank_reg <= fill_bank_next;
            fill_col_reg  <= fill_col_next;
            drain_rem_reg <= drain_rem_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/grm_back.sv @@
// back end: gray sum, two-bank line store access and result buffering
`timescale 1ns / 1ps
`default_nettype none

module grm_back import grm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire cmd_ctl_t                      cmd_ctl,
    input  wire prod_t                         cmd_prod,
    input  wire logic [$clog2(MAX_WIDTH):0]    cmd_rd_addr,
    input  wire logic [$clog2(MAX_WIDTH):0]    cmd_wr_addr,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,     // gray
    output logic                               m_tlast      // row_end
);

    localparam int ADDR_W    = $clog2(MAX_WIDTH) + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W     = PROD_W + 2;

    logic [7:0]        line_mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_last_reg;
    logic              rd_valid_reg, rd_valid_next;
    logic [OCNT_W-1:0] out_count;
    logic [OCNT_W:0]   committed;
    logic              credit_ok;
    logic              pop;
    logic [SUM_W-1:0]  sum;
    logic [7:0]        gray;
    logic [8:0]        out_word;

    // room in the result buffer for everything already in flight
    assign committed = (OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(rd_valid_reg);
    assign credit_ok = (committed < (OCNT_W + 1)'(OUT_DEPTH));
    assign cmd_ready = !cmd_ctl.emit || credit_ok;
    assign pop       = cmd_valid && cmd_ready;

    assign sum  = SUM_W'(cmd_prod.red) + SUM_W'(cmd_prod.green) + SUM_W'(cmd_prod.blue);
    assign gray = (sum[SUM_W-1:16] != '0) ? 8'hFF : sum[15:8];

    assign rd_valid_next = pop && cmd_ctl.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    // read and write never hit the same bank within one command
    always_ff @(posedge aclk) begin
        if (pop && cmd_ctl.wr) begin
            line_mem[cmd_wr_addr] <= gray;
        end
        if (pop && cmd_ctl.emit) begin
            rd_data_reg <= line_mem[cmd_rd_addr];
            rd_last_reg <= cmd_ctl.row_end;
        end
    end

    grm_queue #(
        .DATA_W (9),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (rd_valid_reg),
        .push_ready (),
        .push_data  ({rd_last_reg, rd_data_reg}),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (out_word),
        .count      (out_count)
    );

    assign m_tdata = out_word[7:0];
    assign m_tlast = out_word[8];

endmodule

`default_nettype wire

@@ rtl/grm_checker.sv @@
// port-level checks for the grayscale row mirror, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module grm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // nothing may come out straight after reset
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // command queue is empty after reset, so input is open
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

endmodule

bind grayscale_row_mirror_core grm_checker u_grm_checker (.*);

`default_nettype wire
